/* sv/otsu_pkg.sv */
// Shared constants and types for the Otsu threshold block.
// No dependencies; imported by the arithmetic unit and the top level.
`default_nettype none

package otsu_pkg;

    // Region size limit and histogram shape.
    localparam int MAX_PIXELS = 4096;
    localparam int BIN_W      = 8;
    localparam int NUM_BINS   = 1 << BIN_W;

    // Widths derived from the region limit.
    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W = CNT_W + BIN_W;
    localparam int MAG_W = SUM_W + CNT_W;
    localparam int DEN_W = 2 * CNT_W;
    localparam int NUM_W = 2 * MAG_W;
    localparam int CMP_W = NUM_W + DEN_W;

    typedef logic [BIN_W-1:0] t_bin;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [SUM_W-1:0] t_sum;
    typedef logic [MAG_W-1:0] t_opd;
    typedef logic [NUM_W-1:0] t_prod;

endpackage

`default_nettype wire

/* sv/otsu_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module otsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/otsu_mul.sv */
// Shared multiplier of the sweep sequencer: one registered product a cycle.
// Depends on otsu_pkg for the operand width.
`default_nettype none

module otsu_mul
    import otsu_pkg::*;
(
    input  wire         i_clk,
    input  wire t_opd   i_a,
    input  wire t_opd   i_b,
    output t_prod       o_p
);

    // Product registered before any further use.
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule

`default_nettype wire

/* sv/otsu_threshold_from_pixels.sv */
// Otsu threshold: each counted pixel item reads its histogram bin, then writes it back.
// The item marked last also starts a sweep of the 256 bins; each bin is either skipped
// or has its variance evaluated on the shared multiplier, and the result follows the
// sweep. Input is stalled during the sweep.
// After reset a clearing pass over all 256 bins zeroes the histogram before any item is
// taken; the histogram is cleared again by the sweep itself.
`default_nettype none

module otsu_threshold_from_pixels
    import otsu_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire [7:0]   i_pixel,
    input  wire         i_last_pixel,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [7:0]  o_threshold,
    output logic        o_overflow
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_INC, S_RD, S_GET, S_SB, S_POS, S_NEG, S_DEN,
        S_NUM, S_L0, S_L1, S_R0, S_R1, S_CMP, S_NEXT, S_OUT
    } t_state;

    t_state r_state;

    // Region statistics.
    t_cnt             r_total;
    t_sum             r_sum;
    logic             r_ovf_seen;
    t_bin             r_pix;
    logic             r_last;

    // Sweep state.
    t_bin             r_idx;
    logic             r_done;
    t_cnt             r_wb;
    t_sum             r_sb;
    t_opd             r_pos;
    t_opd             r_mag;
    logic [DEN_W-1:0] r_den;
    t_prod            r_num;
    logic [CMP_W-1:0] r_lhs;
    logic [CMP_W-1:0] r_rhs;
    t_prod            r_max_num;
    logic [DEN_W-1:0] r_max_den;
    t_bin             r_first;
    t_bin             r_lastb;

    // Histogram memory ports.
    logic             ram_we;
    t_bin             ram_waddr;
    t_cnt             ram_wdata;
    t_bin             ram_raddr;
    t_cnt             ram_rdata;

    // Shared multiplier ports.
    t_opd             mul_a;
    t_opd             mul_b;
    t_prod            mul_p;

    logic             in_acc;
    t_cnt             n_wb;
    t_sum             n_sb;
    logic [8:0]       thr_sum;

    otsu_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BINS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    otsu_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && (r_state == S_IDLE);
    assign n_wb    = r_wb + ram_rdata;
    assign n_sb    = r_sb + mul_p[SUM_W-1:0];
    assign thr_sum = {1'b0, r_first} + {1'b0, r_lastb};

    // Memory addressing: pixel lookup while idle, otherwise the sweep index.
    always_comb begin
        ram_raddr = (r_state == S_IDLE) ? i_pixel : r_idx;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        case (r_state)
            S_CLR: begin
                ram_we = 1'b1;
            end
            S_INC: begin
                ram_we    = 1'b1;
                ram_waddr = r_pix;
                ram_wdata = ram_rdata + 1'b1;
            end
            S_GET: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Operand selection for the shared multiplier, one product per step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_GET: begin
                mul_a = t_opd'(r_idx);
                mul_b = t_opd'(ram_rdata);
            end
            S_SB: begin
                mul_a = t_opd'(n_sb);
                mul_b = t_opd'(r_total);
            end
            S_POS: begin
                mul_a = t_opd'(r_sum);
                mul_b = t_opd'(r_wb);
            end
            S_NEG: begin
                mul_a = t_opd'(r_wb);
                mul_b = t_opd'(r_total - r_wb);
            end
            S_DEN: begin
                mul_a = r_mag;
                mul_b = r_mag;
            end
            S_NUM: begin
                mul_a = mul_p[MAG_W-1:0];
                mul_b = t_opd'(r_max_den);
            end
            S_L0: begin
                mul_a = r_num[NUM_W-1:MAG_W];
                mul_b = t_opd'(r_max_den);
            end
            S_L1: begin
                mul_a = r_max_num[MAG_W-1:0];
                mul_b = t_opd'(r_den);
            end
            S_R0: begin
                mul_a = r_max_num[NUM_W-1:MAG_W];
                mul_b = t_opd'(r_den);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // Sequencer: histogram update, bin sweep and result hand-off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_idx      <= '0;
            r_total    <= '0;
            r_sum      <= '0;
            r_ovf_seen <= 1'b0;
            o_valid    <= 1'b0;
            r_max_den  <= DEN_W'(1);
            r_first    <= '0;
            r_lastb    <= '0;
            r_wb       <= '0;
            r_sb       <= '0;
        end else begin
            // A taken result is dropped unless a new one replaces it this cycle.
            if (o_valid && !i_stall && (r_state != S_OUT)) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (&r_idx) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_pix     <= i_pixel;
                        r_last    <= i_last_pixel;
                        r_idx     <= '0;
                        r_done    <= 1'b0;
                        r_wb      <= '0;
                        r_sb      <= '0;
                        r_max_num <= '0;
                        r_max_den <= DEN_W'(1);
                        r_first   <= '0;
                        r_lastb   <= '0;
                        if (r_total >= CNT_W'(MAX_PIXELS)) begin
                            r_ovf_seen <= 1'b1;
                            r_state    <= i_last_pixel ? S_RD : S_IDLE;
                        end else begin
                            r_total <= r_total + 1'b1;
                            r_sum   <= r_sum + t_sum'(i_pixel);
                            r_state <= S_INC;
                        end
                    end
                end
                S_INC: begin
                    r_state <= r_last ? S_RD : S_IDLE;
                end
                S_RD: begin
                    r_state <= S_GET;
                end
                S_GET: begin
                    if (r_done || (n_wb == '0)) begin
                        r_state <= S_NEXT;
                    end else if (n_wb >= r_total) begin
                        r_done  <= 1'b1;
                        r_state <= S_NEXT;
                    end else begin
                        r_wb    <= n_wb;
                        r_state <= S_SB;
                    end
                end
                S_SB: begin
                    r_sb    <= n_sb;
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_pos   <= mul_p[MAG_W-1:0];
                    r_state <= S_NEG;
                end
                S_NEG: begin
                    // Magnitude of the class-mean difference term.
                    if (r_pos >= mul_p[MAG_W-1:0]) begin
                        r_mag <= r_pos - mul_p[MAG_W-1:0];
                    end else begin
                        r_mag <= mul_p[MAG_W-1:0] - r_pos;
                    end
                    r_state <= S_DEN;
                end
                S_DEN: begin
                    r_den   <= mul_p[DEN_W-1:0];
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_num   <= mul_p;
                    r_state <= S_L0;
                end
                S_L0: begin
                    r_lhs   <= {{(CMP_W-NUM_W){1'b0}}, mul_p};
                    r_state <= S_L1;
                end
                S_L1: begin
                    r_lhs   <= r_lhs + {mul_p[MAG_W+DEN_W-1:0], {MAG_W{1'b0}}};
                    r_state <= S_R0;
                end
                S_R0: begin
                    r_rhs   <= {{(CMP_W-NUM_W){1'b0}}, mul_p};
                    r_state <= S_R1;
                end
                S_R1: begin
                    r_rhs   <= r_rhs + {mul_p[MAG_W+DEN_W-1:0], {MAG_W{1'b0}}};
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // Keep the first and last bins that reach the best variance.
                    if (r_lhs >= r_rhs) begin
                        r_lastb   <= r_idx;
                        r_max_num <= r_num;
                        r_max_den <= r_den;
                        if (r_lhs != r_rhs) begin
                            r_first <= r_idx;
                        end
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= (&r_idx) ? S_OUT : S_RD;
                end
                S_OUT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid     <= 1'b1;
                        o_threshold <= thr_sum[8:1];
                        o_overflow  <= r_ovf_seen;
                        r_total     <= '0;
                        r_sum       <= '0;
                        r_wb        <= '0;
                        r_ovf_seen  <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_total_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(MAX_PIXELS))
        else $error("pixel total above limit");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max_den != '0)
        else $error("best denominator is zero");

    a_first_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first <= r_lastb)
        else $error("first best bin after last best bin");

    a_wb_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb <= r_total)
        else $error("background weight above total");
`endif

endmodule

`default_nettype wire
